// ===== rtl/core/bcc_pkg.sv =====
package bcc_pkg;

  localparam int NW = 6;
  localparam int IW = 5;
  localparam int PW = 59;
  localparam int DW = PW + NW;
  localparam int CW = 7;
  localparam int PCW = 3;

  typedef struct packed {
    logic [NW-1:0] count_n;
    logic [NW-1:0] count_k;
  } bcc_in_t;

  typedef struct packed {
    logic [PW-1:0] coefficient;
    logic          status;
  } bcc_out_t;

  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_UPDATE = 3'd4;
  localparam logic [2:0] OP_EMIT   = 3'd5;

  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_NO_IN    = 3'd1;
  localparam logic [2:0] COND_ERR      = 3'd2;
  localparam logic [2:0] COND_DONE     = 3'd3;
  localparam logic [2:0] COND_DIV_MORE = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY = 3'd5;
  localparam logic [2:0] COND_ALWAYS   = 3'd6;

  localparam logic [PCW-1:0] PC_WAIT   = 3'd0;
  localparam logic [PCW-1:0] PC_CHECK  = 3'd1;
  localparam logic [PCW-1:0] PC_LOOP   = 3'd2;
  localparam logic [PCW-1:0] PC_MUL    = 3'd3;
  localparam logic [PCW-1:0] PC_DIV    = 3'd4;
  localparam logic [PCW-1:0] PC_UPDATE = 3'd5;
  localparam logic [PCW-1:0] PC_EMIT   = 3'd6;

  typedef struct packed {
    logic [2:0]     op;
    logic [2:0]     cond;
    logic [PCW-1:0] target;
  } bcc_ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic err;
    logic done;
    logic div_more;
    logic out_busy;
  } bcc_flags_t;

  // Control store: a taken condition jumps to target, otherwise the next step follows.
  function automatic bcc_ctrl_t bcc_rom(input logic [PCW-1:0] pc);
    bcc_ctrl_t w;
    case (pc)
      PC_WAIT:   w = '{op: OP_LOAD,   cond: COND_NO_IN,    target: PC_WAIT};
      PC_CHECK:  w = '{op: OP_NOP,    cond: COND_ERR,      target: PC_EMIT};
      PC_LOOP:   w = '{op: OP_NOP,    cond: COND_DONE,     target: PC_EMIT};
      PC_MUL:    w = '{op: OP_MUL,    cond: COND_NEVER,    target: PC_WAIT};
      PC_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE, target: PC_DIV};
      PC_UPDATE: w = '{op: OP_UPDATE, cond: COND_ALWAYS,   target: PC_LOOP};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: PC_EMIT};
      default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/bcc_seq.sv =====
module bcc_seq
  import bcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bcc_flags_t flags,
  output bcc_ctrl_t  ctrl,
  output logic       idle
);

  logic [PCW-1:0] pc;
  logic [PCW-1:0] pc_next;
  logic           taken;

  assign ctrl = bcc_rom(pc);
  assign idle = (pc == PC_WAIT);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    taken = 1'b0;
      COND_NO_IN:    taken = !flags.in_accept;
      COND_ERR:      taken = flags.err;
      COND_DONE:     taken = flags.done;
      COND_DIV_MORE: taken = flags.div_more;
      COND_OUT_BUSY: taken = flags.out_busy;
      COND_ALWAYS:   taken = 1'b1;
      default:       taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/core/binomial_coefficient_core.sv =====
// Computes n choose k exactly, one transaction at a time. The input is taken
// only while the sequencer waits for work; a finished result sits in an output
// register so the next input can be accepted while it waits to be taken.
// With m = min(k, n-k), the result takes m steps after the input is accepted.
// Each step is a loop test, one multiply by n-i, a bit-serial restoring
// division by i+1 and an update. The result step waits while an earlier result
// is still held by the receiver. k greater than n, or n greater than MAX_N,
// returns coefficient 0 with status 1.
module binomial_coefficient_core
  import bcc_pkg::*;
#(
  parameter int MAX_N = 62
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  bcc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bcc_out_t out_data
);

  bcc_ctrl_t  ctrl;
  bcc_flags_t flags;
  logic       idle;

  logic [NW-1:0] n;
  logic [IW-1:0] m;
  logic [IW-1:0] i;
  logic          err;
  logic [PW-1:0] prod;
  logic [DW-1:0] dvd;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;

  logic          in_accept;
  logic          ld_err;
  logic [NW-1:0] diff;
  logic [NW-1:0] top;
  logic [NW-1:0] divisor;
  logic [NW:0]   rem_sh;
  logic          qbit;

  bcc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  assign in_stall  = !idle;
  assign in_accept = in_valid && idle;

  assign ld_err = (in_data.count_n > NW'(MAX_N)) || (in_data.count_k > in_data.count_n);
  assign diff   = in_data.count_n - in_data.count_k;

  assign top     = n - NW'(i);
  assign divisor = NW'(i) + 1'b1;
  assign rem_sh  = {rem, dvd[DW-1]};
  assign qbit    = (rem_sh >= {1'b0, divisor});

  assign flags.in_accept = in_accept;
  assign flags.err       = err;
  assign flags.done      = (i == m);
  assign flags.div_more  = (cnt != CW'(1));
  assign flags.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !flags.out_busy) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !flags.out_busy) begin
      out_data.coefficient <= err ? '0 : prod;
      out_data.status      <= err;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_accept) begin
          n    <= in_data.count_n;
          m    <= (diff < in_data.count_k) ? diff[IW-1:0] : in_data.count_k[IW-1:0];
          err  <= ld_err;
          i    <= '0;
          prod <= PW'(1);
        end
      end
      OP_MUL: begin
        dvd <= DW'(prod) * DW'(top);
        rem <= '0;
        cnt <= CW'(DW);
      end
      OP_DIV: begin
        // Restoring division: the dividend register fills with quotient bits.
        rem <= qbit ? NW'(rem_sh - {1'b0, divisor}) : rem_sh[NW-1:0];
        dvd <= {dvd[DW-2:0], qbit};
        cnt <= cnt - 1'b1;
      end
      OP_UPDATE: begin
        prod <= dvd[PW-1:0];
        i    <= i + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import bcc_pkg::*;
();

  localparam int MAX_N = 62;
  // The limit lies well above the time the slowest item needs before its result appears.
  localparam int STALL_LIMIT = 20000;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  bcc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  bcc_out_t out_data;

  bcc_out_t pending_results[$];
  int       error_count;
  int       quiet_cycles;
  bit       no_idle;

  binomial_coefficient_core #(.MAX_N(MAX_N)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact n choose k; the wide product never loses bits for n up to MAX_N.
  function automatic bcc_out_t choose_exact(input logic [NW-1:0] n, input logic [NW-1:0] k);
    bcc_out_t         res;
    logic [127:0]     acc;
    logic [NW-1:0]    m;
    int               i;
    res = '0;
    if (n > MAX_N || k > n) begin
      res.status = 1'b1;
      return res;
    end
    m = (n - k < k) ? n - k : k;
    acc = 128'd1;
    for (i = 0; i < m; i++) begin
      acc = acc * (n - i) / (i + 1);
    end
    res.coefficient = acc[PW-1:0];
    return res;
  endfunction

  // Input and output transactions are both observed here.
  always @(posedge clk) begin
    bcc_out_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(choose_exact(in_data.count_n, in_data.count_k));
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, coefficient %0d status %0d",
                   $time, out_data.coefficient, out_data.status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.coefficient !== want.coefficient) begin
            $display("%0t: coefficient expected %0d actual %0d",
                     $time, want.coefficient, out_data.coefficient);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data.status);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver back-pressure: a random hold before each result is taken.
  initial begin
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_item(input logic [NW-1:0] n, input logic [NW-1:0] k);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{count_n: n, count_k: k};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic test_edge_values();
    send_item(6'd0, 6'd0);
    send_item(6'd1, 6'd0);
    send_item(6'd1, 6'd1);
    send_item(6'd62, 6'd0);
    send_item(6'd62, 6'd62);
    send_item(6'd62, 6'd1);
    send_item(6'd62, 6'd61);
    send_item(6'd10, 6'd5);
    send_item(6'd13, 6'd6);
    send_item(6'd62, 6'd31);
    send_item(6'd61, 6'd30);
    send_item(6'd62, 6'd30);
    send_item(6'd42, 6'd21);
  endtask

  // k above n, and n above the largest accepted size, both report an error; one valid item closes the test.
  task automatic test_error_cases();
    send_item(6'd0, 6'd1);
    send_item(6'd0, 6'd63);
    send_item(6'd5, 6'd6);
    send_item(6'd62, 6'd63);
    send_item(6'd63, 6'd0);
    send_item(6'd63, 6'd63);
    send_item(6'd63, 6'd31);
    send_item(6'd42, 6'd21);
  endtask

  // Mostly short computations so the run stays fast, with some errors mixed in.
  task automatic test_random_small(input int count);
    logic [NW-1:0] n;
    logic [NW-1:0] k;
    int            m;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        n = NW'($urandom_range(0, 63));
        k = (n == 63) ? NW'($urandom_range(0, 63)) : NW'($urandom_range(n + 1, 63));
      end else begin
        n = NW'($urandom_range(0, MAX_N));
        m = $urandom_range(0, (n < 4) ? n : 4);
        k = $urandom_range(0, 1) ? NW'(m) : NW'(n - m);
      end
      send_item(n, k);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_full(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(NW'($urandom_range(0, 63)), NW'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    no_idle      = 1'b0;
    error_count  = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_edge_values();
    test_error_cases();
    test_random_small(220);
    test_random_full(50);

    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_seq.sv
rtl/core/binomial_coefficient_core.sv
verif/tb_top.sv
